// ----- src/rmq_pkg.sv -----
// Shared widths, command and result codes, and types of the rating window match queue.
package rmq_pkg;

    localparam int ID_W     = 32;
    localparam int RATING_W = 12;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 12;
    localparam int TMO_W    = 16;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int OCC_W    = 7;
    localparam int CFG_W    = 16;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 88;

    localparam logic [CMD_W-1:0] CMD_PAIR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_PAIRED       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NO_MATCH     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ENQUEUED     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL_DROPPED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVED      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXPIRED      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NONE_EXPIRED = 3'd6;

    localparam logic CFG_RATING_LIMIT = 1'b0;
    localparam logic CFG_TIMEOUT      = 1'b1;

    localparam logic [LIMIT_W-1:0] RATING_LIMIT_RESET = 12'd200;
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET      = 16'd60;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [RATING_W-1:0] rating;
        logic [TIME_W-1:0]   stamp;
    } entry_t;

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic load_new;  // write the incoming entry at the fill position
        logic shift;     // move every entry one cell toward the head
        logic keep;      // the head entry wraps around to the tail
    } cell_ctrl_t;

    // Tests applied to the entry at the head of the chain.
    typedef struct packed {
        logic rating_ok;
        logic id_eq;
        logic expired;
    } judge_t;

endpackage

// ----- src/rmq_cell.sv -----
// One storage cell of the queue chain: holds one entry and takes its neighbor's on a shift.
module rmq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  logic [CNT_W-1:0]    count,
    input  rmq_pkg::cell_ctrl_t ctrl,
    input  rmq_pkg::entry_t     nbr,
    input  rmq_pkg::entry_t     head,
    input  rmq_pkg::entry_t     fresh,
    output rmq_pkg::entry_t     entry
);

    rmq_pkg::entry_t entry_reg;
    rmq_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new && (count == CNT_W'(IDX)))
        begin
            entry_next = fresh;
        end
        else if (ctrl.shift)
        begin
            // The last occupied cell takes the wrapped head entry when it is kept.
            if (ctrl.keep && (count == CNT_W'(IDX + 1)))
            begin
                entry_next = head;
            end
            else
            begin
                entry_next = nbr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- src/rmq_judge.sv -----
// Rating window, id and age tests on the entry at the head of the chain.
module rmq_judge (
    input  rmq_pkg::entry_t                head,
    input  logic [rmq_pkg::ID_W-1:0]       pid,
    input  logic [rmq_pkg::RATING_W-1:0]   prt,
    input  logic [rmq_pkg::TIME_W-1:0]     now,
    input  logic [rmq_pkg::LIMIT_W-1:0]    rating_limit,
    input  logic [rmq_pkg::TMO_W-1:0]      timeout,
    output rmq_pkg::judge_t                res
);

    logic [rmq_pkg::RATING_W-1:0] diff;
    logic signed [rmq_pkg::TIME_W:0] age;
    logic signed [rmq_pkg::TIME_W:0] limit_ext;

    always_comb
    begin
        if (head.rating > prt)
        begin
            diff = head.rating - prt;
        end
        else
        begin
            diff = prt - head.rating;
        end
        // Age is signed, so an entry stamped in the future never expires.
        age       = $signed({1'b0, now}) - $signed({1'b0, head.stamp});
        limit_ext = $signed({{(rmq_pkg::TIME_W + 1 - rmq_pkg::TMO_W){1'b0}}, timeout});
        res.rating_ok = (diff <= rating_limit);
        res.id_eq     = (head.id == pid);
        res.expired   = (age >= limit_ext);
    end

endmodule

// ----- src/rating_window_match_queue.sv -----
// Top level of the rating window match queue: sequencer, cell chain and output register.
// Sequence: an accepted item goes to the scan state, where pair, remove and sweep rotate
// the chain through the N waiting entries, one entry per cycle unless a sweep stalls on a
// busy output (an enqueue does not scan), then to the finish state, which loads the final
// result once the output register is free; the next item is taken only after that.
// Reset: the queue is empty, rating_limit is 200 and timeout_seconds is 60; entry
// storage is not cleared, so the block is ready right after reset.
module rating_window_match_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [rmq_pkg::CFG_W-1:0]      cfg_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entrant_id [31:0], player_rating [43:32], time_seconds [75:44], zero [79:76]
    input  logic [rmq_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd [1:0]
    input  logic [rmq_pkg::CMD_W-1:0]      s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // entry_id [31:0], entry_rating [43:32], entry_time [75:44], occupancy [82:76],
    // zero [87:83]
    output logic [rmq_pkg::M_DATA_W-1:0]   m_tdata,
    // kind [2:0]
    output logic [rmq_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // The sequencer waits for an item, rotates the chain once through every waiting entry
    // unless it is an enqueue, and then hands the final result to the output register.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [rmq_pkg::LIMIT_W-1:0] rating_limit_reg;
    logic [rmq_pkg::TMO_W-1:0]   timeout_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;

    // Latched command of the item being worked on.
    logic [rmq_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [rmq_pkg::ID_W-1:0]     pid_reg, pid_next;
    logic [rmq_pkg::RATING_W-1:0] prt_reg, prt_next;
    logic [rmq_pkg::TIME_W-1:0]   now_reg, now_next;
    logic                         full_reg, full_next;

    // A pending result is held back so that the last expired entry of a sweep
    // can carry the last flag once the scan is known to be over.
    logic                    found_reg, found_next;
    rmq_pkg::entry_t         pend_reg, pend_next;
    logic [CNT_W-1:0]        pend_occ_reg, pend_occ_next;

    // Output register.
    logic                         m_valid_reg, m_valid_next;
    logic [rmq_pkg::KIND_W-1:0]   out_kind_reg, out_kind_next;
    rmq_pkg::entry_t              out_entry_reg, out_entry_next;
    logic [CNT_W-1:0]             out_occ_reg, out_occ_next;
    logic                         out_last_reg, out_last_next;

    logic             out_free;
    logic             drop;
    rmq_pkg::judge_t  judge;
    rmq_pkg::cell_ctrl_t ctrl;
    rmq_pkg::entry_t  fresh;
    rmq_pkg::entry_t  cell_q [QUEUE_DEPTH];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign fresh.id     = s_tdata[31:0];
    assign fresh.rating = s_tdata[43:32];
    assign fresh.stamp  = s_tdata[75:44];

    // The chain: each cell hands its entry toward the head on a shift, and the
    // head entry wraps to the tail when it stays in the queue.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        rmq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .count (count_reg),
            .ctrl  (ctrl),
            .nbr   (cell_q[(i + 1) % QUEUE_DEPTH]),
            .head  (cell_q[0]),
            .fresh (fresh),
            .entry (cell_q[i])
        );
    end

    rmq_judge u_judge (
        .head         (cell_q[0]),
        .pid          (pid_reg),
        .prt          (prt_reg),
        .now          (now_reg),
        .rating_limit (rating_limit_reg),
        .timeout      (timeout_reg),
        .res          (judge)
    );

    // Which head entries leave the queue, per command. A pair takes only the
    // first entry in the window; the rest of the rotation restores order.
    always_comb
    begin
        unique case (cmd_reg)
            rmq_pkg::CMD_PAIR:    drop = !found_reg && judge.rating_ok;
            rmq_pkg::CMD_REMOVE:  drop = judge.id_eq;
            rmq_pkg::CMD_SWEEP:   drop = judge.expired;
            default:              drop = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        cmd_next       = cmd_reg;
        pid_next       = pid_reg;
        prt_next       = prt_reg;
        now_next       = now_reg;
        full_next      = full_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        pend_occ_next  = pend_occ_reg;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_occ_next   = out_occ_reg;
        out_last_next  = out_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    pid_next   = fresh.id;
                    prt_next   = fresh.rating;
                    now_next   = fresh.stamp;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    rem_next   = count_reg;
                    if (s_tuser == rmq_pkg::CMD_ENQUEUE)
                    begin
                        // An enqueue writes the fill position directly, no scan.
                        rem_next = '0;
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.load_new = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (!(cmd_reg == rmq_pkg::CMD_SWEEP && drop && found_reg && !out_free))
                begin
                    // A second expiry pushes out the held one, which is then not last.
                    ctrl.shift = 1'b1;
                    ctrl.keep  = !drop;
                    rem_next   = rem_reg - CNT_W'(1);
                    if (drop)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (cmd_reg != rmq_pkg::CMD_REMOVE)
                        begin
                            found_next    = 1'b1;
                            pend_next     = cell_q[0];
                            pend_occ_next = count_reg - CNT_W'(1);
                        end
                        if (cmd_reg == rmq_pkg::CMD_SWEEP && found_reg)
                        begin
                            m_valid_next   = 1'b1;
                            out_kind_next  = rmq_pkg::KIND_EXPIRED;
                            out_entry_next = pend_reg;
                            out_occ_next   = pend_occ_reg;
                            out_last_next  = 1'b0;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_last_next = 1'b1;
                    if (found_reg)
                    begin
                        out_entry_next = pend_reg;
                        out_occ_next   = pend_occ_reg;
                        out_kind_next  = (cmd_reg == rmq_pkg::CMD_PAIR) ?
                                         rmq_pkg::KIND_PAIRED : rmq_pkg::KIND_EXPIRED;
                    end
                    else
                    begin
                        out_entry_next = '0;
                        out_occ_next   = count_reg;
                        unique case (cmd_reg)
                            rmq_pkg::CMD_PAIR:    out_kind_next = rmq_pkg::KIND_NO_MATCH;
                            rmq_pkg::CMD_ENQUEUE: out_kind_next = full_reg ?
                                                  rmq_pkg::KIND_FULL_DROPPED :
                                                  rmq_pkg::KIND_ENQUEUED;
                            rmq_pkg::CMD_REMOVE:  out_kind_next = rmq_pkg::KIND_REMOVED;
                            default:              out_kind_next = rmq_pkg::KIND_NONE_EXPIRED;
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            rem_reg          <= '0;
            found_reg        <= 1'b0;
            full_reg         <= 1'b0;
            cmd_reg          <= rmq_pkg::CMD_PAIR;
            m_valid_reg      <= 1'b0;
            rating_limit_reg <= rmq_pkg::RATING_LIMIT_RESET;
            timeout_reg      <= rmq_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            found_reg   <= found_next;
            full_reg    <= full_next;
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == rmq_pkg::CFG_RATING_LIMIT)
                begin
                    rating_limit_reg <= cfg_data[rmq_pkg::LIMIT_W-1:0];
                end
                else
                begin
                    timeout_reg <= cfg_data[rmq_pkg::TMO_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg       <= pid_next;
        prt_reg       <= prt_next;
        now_reg       <= now_next;
        pend_reg      <= pend_next;
        pend_occ_reg  <= pend_occ_next;
        out_kind_reg  <= out_kind_next;
        out_entry_reg <= out_entry_next;
        out_occ_reg   <= out_occ_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(rmq_pkg::M_DATA_W - 83){1'b0}},
                       rmq_pkg::OCC_W'(out_occ_reg),
                       out_entry_reg.stamp,
                       out_entry_reg.rating,
                       out_entry_reg.id};

    // The fill count never runs past the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    // Entries still to be examined are always among the waiting ones.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rem_reg <= count_reg))
        else $error("scan counter exceeds fill count");

    // A pair request removes at most one entry.
    a_single_pair: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_SCAN && cmd_reg == rmq_pkg::CMD_PAIR && found_reg && drop))
        else $error("pair request matched twice");

    // An accepted item closes the input until its work is done.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

endmodule
